// ----- rtl/tlgs_pkg.sv -----
package tlgs_pkg;

	// Saturation point of the running glyph count.
	localparam int unsigned COUNT_LIMIT = 4096;
	localparam int unsigned COUNT_W = 13;

	// Configuration register indexes.
	localparam logic CFG_IMAGE_WIDTH = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	// Output tdata layout, packed from bit 0 upwards.
	localparam int unsigned OUT_DATA_W = 48;

	// Broadcast controls that every column cell sees in the same cycle.
	typedef struct packed {
		logic px_set;   // a dark pixel inside the row is transferred
		logic clr_open; // a new text line opens: clear the open mask first
		logic pend_en;  // a pending scan exists: dark pixels go into it too
		logic copy;     // the open line closes: open mask becomes pending mask
		logic load;     // a box scan starts: load the scan chain
		logic shift;    // the scan chain moves one column towards cell 0
	} cell_ctrl_t;

	// Request from the row logic to the box scanner.
	typedef struct packed {
		logic              start;
		logic              frame_end;
		logic signed [7:0] top;
		logic [7:0]        bottom;
	} scan_req_t;

	// One glyph box as it leaves the block.
	typedef struct packed {
		logic [COUNT_W-1:0] number;
		logic [6:0]         right;
		logic signed [7:0]  left;
		logic [7:0]         bottom;
		logic signed [7:0]  top;
	} box_t;

endpackage

// ----- rtl/tlgs_cell.sv -----
module tlgs_cell #(
	parameter int INDEX = 0,
	parameter int CW = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tlgs_pkg::cell_ctrl_t   ctrl,
	input  logic [CW-1:0]          col,
	input  logic                   scan_in,
	output logic                   scan_out
);
	import tlgs_pkg::*;

	logic open_q;
	logic pend_q;
	logic scan_q;
	logic set_bit;
	logic open_d;
	logic pend_d;

	assign set_bit = ctrl.px_set && (col == CW'(INDEX));

	always_comb begin
		open_d = (ctrl.clr_open ? 1'b0 : open_q) | set_bit;
		pend_d = ctrl.copy ? open_d : (pend_q | (set_bit & ctrl.pend_en));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			open_q <= open_d;
			pend_q <= pend_d;
		end
	end

	// The scan chain copy is payload and needs no reset.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			scan_q <= pend_d;
		end else if (ctrl.shift) begin
			scan_q <= scan_in;
		end
	end

	assign scan_out = scan_q;

endmodule

// ----- rtl/tlgs_scan.sv -----
module tlgs_scan #(
	parameter int WW = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tlgs_pkg::scan_req_t               req,
	input  logic                              clr_count,
	input  logic [WW-1:0]                     width,
	input  logic                              head,
	output logic                              busy,
	output logic                              shift,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [tlgs_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tlast
);
	import tlgs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t             state_q;
	logic [WW-1:0]      x_q;
	logic [WW-1:0]      width_q;
	logic               black_q;
	logic signed [7:0]  left_q;
	logic signed [7:0]  top_q;
	logic [7:0]         bottom_q;
	logic               frame_end_q;
	logic [COUNT_W-1:0] count_q;
	logic               hold_valid_q;
	box_t               hold_q;
	logic               out_valid_q;
	box_t               out_q;
	logic               out_last_q;

	logic               can_step;
	logic               finish;
	logic               run_open;
	logic               run_close;
	logic [15:0]        x_ext;
	logic [COUNT_W-1:0] count_inc;
	box_t               new_box;
	logic               load_out;

	assign x_ext     = 16'(x_q);
	assign can_step  = !out_valid_q || m_tready;
	assign finish    = (state_q == ST_SCAN) && can_step && (x_q == width_q);
	assign shift     = (state_q == ST_SCAN) && can_step && (x_q != width_q);
	assign run_open  = shift && head && !black_q;
	assign run_close = shift && !head && black_q;
	assign count_inc = (32'(count_q) < COUNT_LIMIT) ? count_q + COUNT_W'(1) : count_q;
	assign load_out  = (run_close || finish) && hold_valid_q;

	always_comb begin
		new_box.top    = top_q;
		new_box.bottom = bottom_q;
		new_box.left   = left_q;
		new_box.right  = 7'(x_ext + 16'd1);
		new_box.number = count_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			x_q          <= '0;
			black_q      <= 1'b0;
			count_q      <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						state_q <= ST_SCAN;
						x_q     <= '0;
						black_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (finish) begin
						state_q      <= ST_IDLE;
						hold_valid_q <= 1'b0;
					end else if (shift) begin
						x_q <= x_q + WW'(1);
						if (run_open) begin
							black_q <= 1'b1;
						end else if (run_close) begin
							black_q      <= 1'b0;
							hold_valid_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			priority if (finish && frame_end_q) begin
				count_q <= '0;
			end else if (clr_count) begin
				count_q <= '0;
			end else if (run_close) begin
				count_q <= count_inc;
			end

			priority if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && (state_q == ST_IDLE)) begin
			width_q     <= width;
			top_q       <= req.top;
			bottom_q    <= req.bottom;
			frame_end_q <= req.frame_end;
		end
		if (run_open) begin
			left_q <= 8'(x_ext - 16'd1);
		end
		if (run_close) begin
			hold_q <= new_box;
		end
		if (load_out) begin
			out_q      <= hold_q;
			out_last_q <= finish;
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {4'b0000, out_q.number, out_q.right, out_q.left, out_q.bottom, out_q.top};

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == ST_IDLE)
		else $error("scan started while a scan is running");
	a_hold_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> state_q == ST_SCAN)
		else $error("held box survived the end of its scan");
	a_x_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> x_q <= width_q)
		else $error("scan column ran past the row width");
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= COUNT_LIMIT)
		else $error("glyph count passed its limit");
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> !hold_valid_q && state_q == ST_IDLE)
		else $error("scan did not return to idle after its last column");

endmodule

// ----- rtl/text_line_and_glyph_segmenter.sv -----
// Channel   Direction  Payload
// s_*       in         tdata[0] pixel_dark, one pixel per transfer, raster order
// m_*       out        tdata glyph box, tlast = last_box
// cfg_*     in         register writes: index 0 image_width, index 1 image_height
//
// Pixels are taken one per cycle while the scanner is idle. At the end of the row after
// one that closes a text line, or at the end of a frame that closes one, the box scanner
// walks the column mask one column per cycle while the output is not stalled.
// Pixels are not taken while the scanner walks; configuration writes are taken at any time.
// Reset is asynchronous and active low; it leaves the block at the first pixel of a frame.
// A stalled output holds its transfer; the scanner pauses with it.
module text_line_and_glyph_segmenter #(
	parameter int MAX_WIDTH = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// s_tdata fields from bit 0: pixel_dark, then zero padding.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,
	// m_tdata fields from bit 0: line_top[7:0], line_bottom[15:8], glyph_left[23:16],
	// glyph_right[30:24], glyph_number[43:31], then zero padding.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [tlgs_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [7:0]                        cfg_data
);
	import tlgs_pkg::*;

	// Column counter, clamped width and row counter widths all follow the maxima.
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	logic [7:0]        width_cfg_q;
	logic [7:0]        height_cfg_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic              row_dark_q;
	logic              inside_q;
	logic signed [7:0] open_top_q;
	logic              pend_q;
	logic signed [7:0] pend_top_q;

	logic [WW-1:0]     w_eff;
	logic [HW-1:0]     h_eff;
	logic              accept;
	logic              in_row;
	logic              px;
	logic              end_row;
	logic              end_frame;
	logic              inside_n;
	logic              row_dark_n;
	logic              close;
	logic signed [7:0] open_top_n;
	logic [15:0]       row_ext;
	logic              busy;
	logic              shift;
	logic              head;
	logic              clr_count;
	cell_ctrl_t        cctrl;
	scan_req_t         req;
	logic [MAX_WIDTH:0] chain;

	// Register values out of range are clamped: zero acts as one, large values as the maximum.
	always_comb begin
		priority if (width_cfg_q == 8'd0) begin
			w_eff = WW'(1);
		end else if (int'(width_cfg_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_cfg_q);
		end
		priority if (height_cfg_q == 8'd0) begin
			h_eff = HW'(1);
		end else if (int'(height_cfg_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_cfg_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_cfg_q  <= 8'd128;
			height_cfg_q <= 8'd128;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  width_cfg_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = !busy;
	assign accept   = s_tvalid && s_tready;
	assign row_ext  = 16'(row_q);

	// A column counter at or beyond a freshly shrunk width ends the row at once, keeping
	// such a pixel out of the mask; a too-high row counter ends the frame with its row.
	assign in_row    = WW'(col_q) < w_eff;
	assign px        = s_tdata[0] && in_row;
	assign end_row   = (WW'(col_q) + WW'(1)) >= w_eff;
	assign end_frame = end_row && ((HW'(row_q) + HW'(1)) >= h_eff);

	always_comb begin
		inside_n   = inside_q | px;
		row_dark_n = row_dark_q | px;
		open_top_n = (px && !inside_q) ? 8'(row_ext - 16'd1) : open_top_q;
		// A line closes at the first all-light row after it opened.
		close      = end_row && inside_n && !row_dark_n;
	end

	// A pending line is scanned at the end of the row after its closing row. A line that
	// closes on the last row of the frame is scanned at once, with its bottom past the image.
	always_comb begin
		req.start     = accept && end_row && (pend_q || (end_frame && close));
		req.frame_end = end_frame;
		req.top       = pend_q ? pend_top_q : open_top_n;
		req.bottom    = pend_q ? row_ext[7:0] : 8'(row_ext + 16'd1);
		clr_count     = accept && end_frame && !req.start;
	end

	always_comb begin
		cctrl.px_set   = accept && px;
		cctrl.clr_open = accept && px && !inside_q;
		cctrl.pend_en  = pend_q;
		cctrl.copy     = accept && close;
		cctrl.load     = req.start;
		cctrl.shift    = shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			row_dark_q <= 1'b0;
			inside_q   <= 1'b0;
			open_top_q <= '0;
			pend_q     <= 1'b0;
			pend_top_q <= '0;
		end else if (accept) begin
			open_top_q <= open_top_n;
			if (end_row) begin
				col_q      <= '0;
				row_dark_q <= 1'b0;
				if (end_frame) begin
					row_q    <= '0;
					inside_q <= 1'b0;
					pend_q   <= 1'b0;
				end else begin
					row_q    <= row_q + RW'(1);
					inside_q <= inside_n && !close;
					pend_q   <= close;
					if (close) begin
						pend_top_q <= open_top_n;
					end
				end
			end else begin
				col_q      <= col_q + CW'(1);
				row_dark_q <= row_dark_n;
				inside_q   <= inside_n;
			end
		end
	end

	// One cell per column. Each holds its bit of the open and pending masks and a scan bit
	// that moves one cell towards column 0 on every scan step.
	assign chain[MAX_WIDTH] = 1'b0;

	for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
		tlgs_cell #(
			.INDEX (i),
			.CW    (CW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cctrl),
			.col      (col_q),
			.scan_in  (chain[i+1]),
			.scan_out (chain[i])
		);
	end

	assign head = chain[0];

	tlgs_scan #(
		.WW (WW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.clr_count (clr_count),
		.width     (w_eff),
		.head      (head),
		.busy      (busy),
		.shift     (shift),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ----- tb/sv/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tlgs_pkg::*;

	localparam int          CLK_PERIOD     = 8;
	localparam int          MAX_W          = 128;
	localparam int          MAX_H          = 128;
	// At most this many boxes may be produced by a single pixel.
	localparam int          MAX_BOXES      = 64;
	// A box scan walks the whole column mask, so a pixel that starts a scan
	// keeps the block busy for a walk across the whole row even when the
	// scan finds no glyph. Leave twice that before touching the registers.
	localparam int          SETTLE_CYCLES  = 2 * MAX_W + 16;
	localparam int          RANDOM_PIXELS  = 320;
	localparam int unsigned CYCLE_LIMIT    = 1000000;

	// An expected glyph box together with the end-of-pixel marker.
	typedef struct packed {
		box_t box;
		logic last;
	} glyph_box_t;

	// Tracks the segmenter state alongside the block and holds, in order, the
	// glyph boxes that the pixels transferred so far should produce.
	class box_predictor;
		bit [7:0]     width_reg = 8'd128;
		bit [7:0]     height_reg = 8'd128;
		int unsigned  col = 0;
		int unsigned  row = 0;
		bit           row_dark = 1'b0;
		bit           in_line = 1'b0;
		int           line_top = 0;
		bit [127:0]   line_cols = '0;
		bit           scan_due = 1'b0;
		int           scan_top = 0;
		bit [127:0]   scan_cols = '0;
		int unsigned  glyphs = 0;
		glyph_box_t   boxes_due[$];
		int unsigned  boxes_checked = 0;
		int unsigned  errors = 0;

		function int unsigned fit(int unsigned v, int unsigned hi);
			return (v < 1) ? 1 : ((v > hi) ? hi : v);
		endfunction

		function void write_reg(logic idx, bit [7:0] v);
			if (idx == CFG_IMAGE_WIDTH) begin
				width_reg = v;
			end else begin
				height_reg = v;
			end
		endfunction

		// Every light-to-dark run of the mask that closes before the right
		// edge is one glyph. Runs still dark at the last column are lost.
		function void find_glyphs(bit [127:0] cols, int top, int unsigned bottom,
				int unsigned w, int first);
			bit         in_run;
			int         left;
			glyph_box_t b;
			in_run = 1'b0;
			left = 0;
			for (int unsigned x = 0; x < w; x++) begin
				if (cols[x] && !in_run) begin
					in_run = 1'b1;
					left = int'(x) - 1;
				end else if (!cols[x] && in_run) begin
					in_run = 1'b0;
					if (glyphs < COUNT_LIMIT) glyphs++;
					if (boxes_due.size() - first < MAX_BOXES) begin
						b.box.top = top[7:0];
						b.box.bottom = bottom[7:0];
						b.box.left = left[7:0];
						// The right bound of a glyph ending at column 126 of a
						// 128-wide image is 128, which wraps to zero.
						b.box.right = 7'(x + 1);
						b.box.number = glyphs[COUNT_W-1:0];
						b.last = 1'b0;
						boxes_due.push_back(b);
					end
				end
			end
		endfunction

		function void note_pixel(bit dark);
			int unsigned w;
			int unsigned h;
			int          first;
			glyph_box_t  b;
			w = fit(width_reg, MAX_W);
			h = fit(height_reg, MAX_H);
			first = boxes_due.size();
			// A column left over from a wider setting lies outside the row.
			if (dark && col < w) begin
				if (!in_line) begin
					in_line = 1'b1;
					line_top = int'(row) - 1;
					line_cols = '0;
				end
				row_dark = 1'b1;
				line_cols[col] = 1'b1;
				if (scan_due) scan_cols[col] = 1'b1;
			end
			if (col + 1 >= w) begin
				if (scan_due) begin
					find_glyphs(scan_cols, scan_top, row, w, first);
					scan_due = 1'b0;
				end
				if (in_line && !row_dark) begin
					in_line = 1'b0;
					scan_due = 1'b1;
					scan_top = line_top;
					scan_cols = line_cols;
				end
				row_dark = 1'b0;
				col = 0;
				if (row + 1 >= h) begin
					// A line closed by the last row is scanned as if the
					// row below the image were there; a line still open
					// is dropped.
					if (scan_due) find_glyphs(scan_cols, scan_top, row + 1, w, first);
					scan_due = 1'b0;
					in_line = 1'b0;
					row = 0;
					glyphs = 0;
				end else begin
					row++;
				end
			end else begin
				col++;
			end
			if (boxes_due.size() > first) begin
				b = boxes_due.pop_back();
				b.last = 1'b1;
				boxes_due.push_back(b);
			end
		endfunction

		function void compare(string field, logic signed [31:0] want,
				logic signed [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_box(logic [OUT_DATA_W-1:0] data, logic last);
			glyph_box_t want;
			box_t       got;
			if (boxes_due.size() == 0) begin
				$display("%0t: glyph box expected none, got tdata %h tlast %b",
					$time, data, last);
				errors++;
				return;
			end
			want = boxes_due.pop_front();
			got = data[$bits(box_t)-1:0];
			boxes_checked++;
			compare("line_top", want.box.top, got.top);
			compare("line_bottom", want.box.bottom, got.bottom);
			compare("glyph_left", want.box.left, got.left);
			compare("glyph_right", want.box.right, got.right);
			compare("glyph_number", want.box.number, got.number);
			compare("last_box", want.last, last);
			compare("padding", 0, data[OUT_DATA_W-1:$bits(box_t)]);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [7:0]            cfg_data;

	box_predictor sb;
	// While set, neither side inserts idle cycles.
	bit           calm = 1'b0;

	text_line_and_glyph_segmenter #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),     // pixel_dark, then zero padding
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),     // line_top, line_bottom, glyph_left, glyph_right, glyph_number
		.m_tlast(m_tlast),     // last_box
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Mostly short pauses, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// A row of ink made of short dark runs separated by short light runs,
	// sometimes pushed against the left or right edge.
	function automatic bit [127:0] glyph_row(int w);
		bit [127:0] g;
		int         x;
		int         len;
		g = '0;
		x = $urandom_range(0, 2);
		while (x < w) begin
			len = $urandom_range(1, 4);
			for (int k = 0; k < len && x + k < w; k++) g[x + k] = 1'b1;
			x += len + $urandom_range(1, 3);
		end
		if ($urandom_range(0, 3) == 0) g[0] = 1'b1;
		if ($urandom_range(0, 3) == 0) g[w - 1] = 1'b1;
		return g;
	endfunction

	// Every transfer on both sides and every register write is seen here, at
	// the clock edge where it happens. A pixel is noted before a box is
	// checked, so the order of the queue never depends on scheduling.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) sb.write_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready) sb.note_pixel(s_tdata[0]);
			if (m_tvalid && m_tready) sb.check_box(m_tdata, m_tlast);
		end
	end

	// The receiving side: bursts of ready broken by stalls of random length.
	initial begin
		int g;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			g = gap_len();
			if (g > 0) begin
				m_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	// Offer one pixel and hold it until the transfer completes. Valid is left
	// high on return so that a following pixel can go out back to back.
	task automatic send_pixel(bit dark);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, dark};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_row(bit [127:0] r, int w);
		for (int x = 0; x < w; x++) send_pixel(r[x]);
	endtask

	// Pixels written as a string of ones and zeros; spaces only help reading.
	task automatic send_pattern(string s);
		for (int i = 0; i < s.len(); i++) begin
			if (s[i] == "1") send_pixel(1'b1);
			else if (s[i] == "0") send_pixel(1'b0);
		end
	endtask

	// Text-like content: blank rows, bands of one to three rows that share a
	// glyph pattern, and the odd row of noise. It may stop part way into a
	// row, which leaves the block mid-row for the next register change.
	task automatic send_text(int w, int n);
		bit [127:0] glyphs;
		bit [127:0] r_bits;
		int         band;
		int         r;
		glyphs = '0;
		r_bits = '0;
		band = 0;
		for (int i = 0; i < n; i++) begin
			if (i % w == 0) begin
				r = $urandom_range(0, 99);
				if (band > 0) begin
					r_bits = (r < 15) ? (glyphs | glyph_row(w)) : glyphs;
					band--;
				end else if (r < 45) begin
					glyphs = glyph_row(w);
					r_bits = glyphs;
					band = $urandom_range(0, 2);
				end else if (r < 53) begin
					r_bits = {$urandom, $urandom, $urandom, $urandom};
				end else begin
					r_bits = '0;
				end
			end
			send_pixel(r_bits[i % w]);
		end
	endtask

	// Stop offering pixels, wait for every box still owed, then give the box
	// scanner time to finish a walk that finds nothing more.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.boxes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_size(bit [7:0] w, bit [7:0] h);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		bit [127:0]  wide_row;
		bit [7:0]    w8;
		bit [7:0]    h8;
		int unsigned we;
		int unsigned he;
		int          n;
		int          phase;
		int          random_px;
		sb = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		drain();

		// A line on the top row so that its top lies above the image, a
		// glyph in the first column, a run reaching the right edge, and a
		// second line still open when the frame ends.
		set_size(8'd4, 8'd3);
		send_pattern("1011 0000 0001");
		drain();
		// A line closed by the last row: its boxes leave at the frame end.
		set_size(8'd3, 8'd2);
		send_pattern("010 000");
		drain();
		// The width shrinks below the column reached, which ends the row at
		// the next pixel without storing it.
		set_size(8'd4, 8'd4);
		send_pattern("110");
		drain();
		set_size(8'd2, 8'd4);
		send_pattern("1 00 00");
		drain();
		// A width of zero acts as one; with a height of one each pixel is a
		// frame of its own, and the row counter left at three ends it.
		set_size(8'd0, 8'd1);
		send_pattern("1 0");
		drain();

		// Widest image: glyphs from the first column, one ending at column
		// 126 whose right bound wraps, and the boxes leaving at frame end.
		set_size(8'd128, 8'd2);
		wide_row = glyph_row(MAX_W);
		wide_row[0] = 1'b1;
		wide_row[126] = 1'b1;
		wide_row[127] = 1'b0;
		send_row(wide_row, MAX_W);
		send_row('0, MAX_W);
		drain();

		// Tallest image, with a height above the maximum; the closing rows
		// put a line right at the bottom.
		set_size(8'd2, 8'hFF);
		send_text(2, 2 * (MAX_H - 2));
		send_pattern("10 00");

		// Random part: mostly small images so that frames, lines and boxes
		// come often, with the odd clamped or extreme size and stretches in
		// which neither side idles.
		phase = 0;
		random_px = 0;
		while (random_px < RANDOM_PIXELS) begin
			if (phase == 0) begin
				w8 = 8'd127;
				h8 = 8'($urandom_range(1, 3));
			end else begin
				case ($urandom_range(0, 15))
					0: begin
						w8 = 8'd0;
						h8 = 8'($urandom_range(1, 8));
					end
					1: begin
						w8 = 8'($urandom_range(129, 255));
						h8 = 8'($urandom_range(1, 3));
					end
					2: begin
						w8 = 8'($urandom_range(1, 3));
						h8 = 8'($urandom_range(129, 255));
					end
					3: begin
						w8 = 8'($urandom_range(2, 12));
						h8 = 8'd0;
					end
					default: begin
						w8 = 8'($urandom_range(2, 12));
						h8 = 8'($urandom_range(2, 10));
					end
				endcase
			end
			we = sb.fit(w8, MAX_W);
			he = sb.fit(h8, MAX_H);
			n = $urandom_range(we, we * he * 2);
			if (n > 300) n = 300;
			if (n > RANDOM_PIXELS - random_px) n = RANDOM_PIXELS - random_px;
			drain();
			calm = ($urandom_range(0, 3) == 0);
			set_size(w8, h8);
			send_text(we, n);
			random_px += n;
			phase++;
		end

		calm = 1'b0;
		drain();
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
